@@ rtl/fixed_block_pool_allocator_macros.svh @@
// assertion helpers for the pool allocator
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define FBPA_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed: same-cycle check");
// next-cycle implication
`define FBPA_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed: next-cycle check");
`else
`define FBPA_ASSERT_NOW(label, clk, rst, cond, expr)
`define FBPA_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif

`endif

@@ rtl/fbpa_pkg.sv @@
package fbpa_pkg;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_INIT  = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   localparam logic [1:0] REG_BASE  = 2'd0;
   localparam logic [1:0] REG_SIZE  = 2'd1;
   localparam logic [1:0] REG_COUNT = 2'd2;

   localparam logic [7:0] LIST_END = 8'hFF;

   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = 5;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_ALLOC,
      OP_FREE,
      OP_INIT
   } op_type;

   typedef struct packed {
      logic   capture;
      logic   div_step;
      logic   mem_rd;
      logic   walk_step;
      logic   finish;
      op_type finish_op;
   } dp_cmd_type;

   typedef struct packed {
      logic list_empty;
      logic count_zero;
      logic walk_last;
      logic div_last;
   } dp_stat_type;

   typedef struct packed {
      logic        en;
      logic [1:0]  index;
      logic [31:0] data;
   } cfg_wr_type;

endpackage

@@ rtl/fbpa_ctrl.sv @@
module fbpa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             cmd,
   input  fbpa_pkg::dp_stat_type  stat,
   output fbpa_pkg::dp_cmd_type   dp_cmd,
   output logic                   busy,
   output logic                   rsp_valid
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC_READ,
      ST_ALLOC_DONE,
      ST_DIV,
      ST_FREE_DONE,
      ST_INIT_WALK,
      ST_NOP_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   always_comb begin
      state_in            = state_ff;
      dp_cmd.capture      = 1'b0;
      dp_cmd.div_step     = 1'b0;
      dp_cmd.mem_rd       = 1'b0;
      dp_cmd.walk_step    = 1'b0;
      dp_cmd.finish       = 1'b0;
      dp_cmd.finish_op    = fbpa_pkg::OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               dp_cmd.capture = 1'b1;
               case (cmd)
                  fbpa_pkg::CMD_ALLOC: state_in = ST_ALLOC_READ;
                  fbpa_pkg::CMD_FREE:  state_in = ST_DIV;
                  fbpa_pkg::CMD_INIT:  state_in = ST_INIT_WALK;
                  default:             state_in = ST_NOP_DONE;
               endcase
            end
         end
         ST_ALLOC_READ: begin
            if (stat.list_empty) begin
               dp_cmd.finish    = 1'b1;
               dp_cmd.finish_op = fbpa_pkg::OP_ALLOC;
               state_in         = ST_IDLE;
            end else begin
               dp_cmd.mem_rd = 1'b1;
               state_in      = ST_ALLOC_DONE;
            end
         end
         ST_ALLOC_DONE: begin
            dp_cmd.finish    = 1'b1;
            dp_cmd.finish_op = fbpa_pkg::OP_ALLOC;
            state_in         = ST_IDLE;
         end
         ST_DIV: begin
            dp_cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_FREE_DONE;
            end
         end
         ST_FREE_DONE: begin
            dp_cmd.finish    = 1'b1;
            dp_cmd.finish_op = fbpa_pkg::OP_FREE;
            state_in         = ST_IDLE;
         end
         ST_INIT_WALK: begin
            if (stat.count_zero) begin
               dp_cmd.finish    = 1'b1;
               dp_cmd.finish_op = fbpa_pkg::OP_INIT;
               state_in         = ST_IDLE;
            end else begin
               dp_cmd.walk_step = 1'b1;
               if (stat.walk_last) begin
                  dp_cmd.finish    = 1'b1;
                  dp_cmd.finish_op = fbpa_pkg::OP_INIT;
                  state_in         = ST_IDLE;
               end
            end
         end
         ST_NOP_DONE: begin
            dp_cmd.finish    = 1'b1;
            dp_cmd.finish_op = fbpa_pkg::OP_NONE;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= dp_cmd.finish;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/fbpa_datapath.sv @@
module fbpa_datapath #(
   parameter int MAX_BLOCKS = 254
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fbpa_pkg::dp_cmd_type   dp_cmd,
   output fbpa_pkg::dp_stat_type  stat,
   input  fbpa_pkg::cfg_wr_type   cfg_wr,
   input  logic [31:0]            req_free_address,
   output logic [31:0]            cfg_base,
   output logic [15:0]            cfg_size,
   output logic [7:0]             cfg_count,
   output logic [31:0]            rsp_block_address,
   output logic [7:0]             rsp_block_number,
   output logic [1:0]             rsp_status,
   output logic                   rsp_pool_empty
);

   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam logic [7:0] MAX_NUM = 8'(MAX_BLOCKS);

   logic [31:0] base_ff;
   logic [15:0] size_ff;
   logic [7:0]  count_ff;
   logic [7:0]  head_ff, head_in;

   logic [7:0]  link_mem [MAX_BLOCKS];
   logic [7:0]  rd_ff;
   logic [23:0] prod_ff;

   logic [31:0] div_ff;
   logic [15:0] rem_ff;
   logic        below_ff;
   logic [fbpa_pkg::DIV_CNT_W-1:0] step_ff;
   logic [IDX_W-1:0] walk_ff;

   logic [31:0] res_addr_ff, res_addr_in;
   logic [7:0]  res_num_ff, res_num_in;
   logic [1:0]  res_status_ff, res_status_in;
   logic        res_empty_ff;

   logic [15:0] esize;
   logic [7:0]  ecount;
   logic        list_empty;
   logic        free_ok;
   logic [16:0] div_shift;
   logic [17:0] div_diff;
   logic [7:0]  walk_next;
   logic        walk_last;

   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [7:0]       wr_data;

   // a zero size acts as one, count saturates at the pool depth
   assign esize      = (size_ff == 16'd0) ? 16'd1 : size_ff;
   assign ecount     = (count_ff > MAX_NUM) ? MAX_NUM : count_ff;
   assign list_empty = (head_ff >= MAX_NUM);

   assign walk_next = 8'(walk_ff) + 8'd1;
   assign walk_last = (walk_next == ecount);

   assign div_shift = {rem_ff, div_ff[31]};
   assign div_diff  = {1'b0, div_shift} - {2'b00, esize};

   assign free_ok = !below_ff && (rem_ff == 16'd0) && (div_ff < 32'(ecount));

   assign stat.list_empty = list_empty;
   assign stat.count_zero = (ecount == 8'd0);
   assign stat.walk_last  = walk_last;
   assign stat.div_last   = (step_ff == fbpa_pkg::DIV_CNT_W'(fbpa_pkg::DIV_STEPS - 1));

   always_comb begin
      head_in       = head_ff;
      res_addr_in   = 32'd0;
      res_num_in    = fbpa_pkg::LIST_END;
      res_status_in = fbpa_pkg::STATUS_OK;
      wr_en         = dp_cmd.walk_step;
      wr_idx        = walk_ff;
      wr_data       = walk_last ? fbpa_pkg::LIST_END : walk_next;
      if (dp_cmd.finish) begin
         case (dp_cmd.finish_op)
            fbpa_pkg::OP_ALLOC: begin
               if (list_empty) begin
                  res_status_in = fbpa_pkg::STATUS_EMPTY;
               end else begin
                  res_addr_in = base_ff + 32'(prod_ff);
                  res_num_in  = head_ff;
                  head_in     = rd_ff;
               end
            end
            fbpa_pkg::OP_FREE: begin
               if (free_ok) begin
                  wr_en      = 1'b1;
                  wr_idx     = div_ff[IDX_W-1:0];
                  wr_data    = head_ff;
                  head_in    = div_ff[7:0];
                  res_num_in = div_ff[7:0];
               end else begin
                  res_status_in = fbpa_pkg::STATUS_INVALID;
               end
            end
            fbpa_pkg::OP_INIT: begin
               head_in = (ecount == 8'd0) ? fbpa_pkg::LIST_END : 8'd0;
            end
            default: begin
               head_in = head_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= 32'd0;
         size_ff  <= 16'd1;
         count_ff <= 8'd1;
         head_ff  <= fbpa_pkg::LIST_END;
      end else begin
         if (cfg_wr.en) begin
            case (cfg_wr.index)
               fbpa_pkg::REG_BASE:  base_ff  <= cfg_wr.data;
               fbpa_pkg::REG_SIZE:  size_ff  <= cfg_wr.data[15:0];
               fbpa_pkg::REG_COUNT: count_ff <= cfg_wr.data[7:0];
               default:             base_ff  <= base_ff;
            endcase
         end
         head_ff <= head_in;
      end
   end

   // link store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_idx] <= wr_data;
      end
      if (dp_cmd.mem_rd) begin
         rd_ff   <= link_mem[head_ff[IDX_W-1:0]];
         prod_ff <= 24'(head_ff) * 24'(esize);
      end
   end

   // restoring divider, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         div_ff   <= req_free_address - base_ff;
         below_ff <= (req_free_address < base_ff);
         rem_ff   <= 16'd0;
         step_ff  <= '0;
         walk_ff  <= '0;
      end else begin
         if (dp_cmd.div_step) begin
            if (!div_diff[17]) begin
               rem_ff <= div_diff[15:0];
               div_ff <= {div_ff[30:0], 1'b1};
            end else begin
               rem_ff <= div_shift[15:0];
               div_ff <= {div_ff[30:0], 1'b0};
            end
            step_ff <= step_ff + fbpa_pkg::DIV_CNT_W'(1);
         end
         if (dp_cmd.walk_step) begin
            walk_ff <= walk_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.finish) begin
         res_addr_ff   <= res_addr_in;
         res_num_ff    <= res_num_in;
         res_status_ff <= res_status_in;
         res_empty_ff  <= (head_in >= MAX_NUM);
      end
   end

   assign cfg_base          = base_ff;
   assign cfg_size          = size_ff;
   assign cfg_count         = count_ff;
   assign rsp_block_address = res_addr_ff;
   assign rsp_block_number  = res_num_ff;
   assign rsp_status        = res_status_ff;
   assign rsp_pool_empty    = res_empty_ff;

endmodule

@@ rtl/fixed_block_pool_allocator.sv @@
// channel   direction  handshake                      payload
// request   in         start, busy                    req_cmd, req_free_address
// response  out        rsp_valid (one-cycle strobe)   rsp_block_address, rsp_block_number,
//                                                     rsp_status, rsp_pool_empty
// csr       in/out     psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// allocate does a link read, then a head update, from accept to strobe; an empty list skips the read
// free runs the 32-step bit-serial divider of the offset by block size before its result
// initialize writes the links in order (count capped at the pool depth), none for a zero count
// undefined commands change nothing and return an OK result; initialize writes one link per cycle
// synchronous active-high reset empties the free list; link store contents are not cleared
// busy is high from the cycle after accept until the strobe; the result cannot be stalled
`include "fixed_block_pool_allocator_macros.svh"

module fixed_block_pool_allocator #(
   parameter int MAX_BLOCKS = 254
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_free_address,
   output logic        rsp_valid,
   output logic [31:0] rsp_block_address,
   output logic [7:0]  rsp_block_number,
   output logic [1:0]  rsp_status,
   output logic        rsp_pool_empty,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   fbpa_pkg::dp_cmd_type  dp_cmd;
   fbpa_pkg::dp_stat_type dp_stat;
   fbpa_pkg::cfg_wr_type  cfg_wr;

   logic [31:0] cfg_base;
   logic [15:0] cfg_size;
   logic [7:0]  cfg_count;

   assign pready       = 1'b1;
   assign cfg_wr.en    = psel && penable && pwrite;
   assign cfg_wr.index = paddr[3:2];
   assign cfg_wr.data  = pwdata;

   always_comb begin
      case (paddr[3:2])
         fbpa_pkg::REG_BASE:  prdata = cfg_base;
         fbpa_pkg::REG_SIZE:  prdata = {16'd0, cfg_size};
         fbpa_pkg::REG_COUNT: prdata = {24'd0, cfg_count};
         default:             prdata = 32'd0;
      endcase
   end

   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (req_cmd),
      .stat      (dp_stat),
      .dp_cmd    (dp_cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   fbpa_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .dp_cmd            (dp_cmd),
      .stat              (dp_stat),
      .cfg_wr            (cfg_wr),
      .req_free_address  (req_free_address),
      .cfg_base          (cfg_base),
      .cfg_size          (cfg_size),
      .cfg_count         (cfg_count),
      .rsp_block_address (rsp_block_address),
      .rsp_block_number  (rsp_block_number),
      .rsp_status        (rsp_status),
      .rsp_pool_empty    (rsp_pool_empty)
   );

   // every accepted item makes the block busy in the cycle after accept
   `FBPA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // the result strobe comes only as the block returns to idle
   `FBPA_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy)
   // results never come back to back
   `FBPA_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   // a failed allocate gives no block and reports the pool empty
   `FBPA_ASSERT_NOW(a_empty_result, clock, reset,
      rsp_valid && (rsp_status == fbpa_pkg::STATUS_EMPTY),
      rsp_pool_empty && (rsp_block_number == fbpa_pkg::LIST_END) && (rsp_block_address == 32'd0))

endmodule

@@ tb/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         POOL_DEPTH = 254;
   localparam logic [1:0] CMD_UNDEF  = 2'd3;

   typedef struct packed {
      logic [31:0] addr;
      logic [7:0]  num;
      logic [1:0]  status;
      logic        empty;
   } pool_result_type;

   // mirror of the free list plus the results still owed by the block
   class pool_tracker_type;
      logic [31:0]     cfg_base  = 32'd0;
      logic [15:0]     cfg_size  = 16'd1;
      logic [7:0]      cfg_count = 8'd1;
      logic [7:0]      links [POOL_DEPTH];
      logic [7:0]      head = fbpa_pkg::LIST_END;
      pool_result_type awaited [$];
      int              errors = 0;

      function void set_register(logic [1:0] idx, logic [31:0] value);
         case (idx)
            fbpa_pkg::REG_BASE:  cfg_base  = value;
            fbpa_pkg::REG_SIZE:  cfg_size  = value[15:0];
            fbpa_pkg::REG_COUNT: cfg_count = value[7:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] block_bytes();
         return (cfg_size == 16'd0) ? 32'd1 : 32'(cfg_size);
      endfunction

      function pool_result_type note_request(logic [1:0] cmd, logic [31:0] addr);
         pool_result_type r;
         logic [31:0]     sz, off, q, n;
         r.addr   = 32'd0;
         r.num    = fbpa_pkg::LIST_END;
         r.status = fbpa_pkg::STATUS_OK;
         sz = block_bytes();
         n  = (cfg_count > POOL_DEPTH) ? 32'(POOL_DEPTH) : 32'(cfg_count);
         case (cmd)
            fbpa_pkg::CMD_ALLOC: begin
               if (head >= POOL_DEPTH) begin
                  r.status = fbpa_pkg::STATUS_EMPTY;
               end else begin
                  r.addr = cfg_base + 32'(head) * sz;
                  r.num  = head;
                  head   = links[head];
               end
            end
            fbpa_pkg::CMD_FREE: begin
               r.status = fbpa_pkg::STATUS_INVALID;
               if (addr >= cfg_base) begin
                  off = addr - cfg_base;
                  q   = off / sz;
                  if (off % sz == 32'd0 && q < n) begin
                     links[q] = head;
                     head     = q[7:0];
                     r.num    = q[7:0];
                     r.status = fbpa_pkg::STATUS_OK;
                  end
               end
            end
            fbpa_pkg::CMD_INIT: begin
               if (n == 32'd0) begin
                  head = fbpa_pkg::LIST_END;
               end else begin
                  for (int i = 0; i + 1 < n; i++) links[i] = 8'(i + 1);
                  links[n - 1] = fbpa_pkg::LIST_END;
                  head = 8'd0;
               end
            end
            default: ;
         endcase
         r.empty = (head >= POOL_DEPTH);
         awaited.push_back(r);
         return r;
      endfunction

      function void check_response(pool_result_type got);
         pool_result_type want;
         if (awaited.size() == 0) begin
            $error("response strobe with no item pending");
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (got.addr !== want.addr) begin
            $error("block_address: expected %h, got %h", want.addr, got.addr);
            errors++;
         end
         if (got.num !== want.num) begin
            $error("block_number: expected %0d, got %0d", want.num, got.num);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.empty !== want.empty) begin
            $error("pool_empty: expected %b, got %b", want.empty, got.empty);
            errors++;
         end
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_cmd;
   logic [31:0] req_free_address;
   logic        rsp_valid;
   logic [31:0] rsp_block_address;
   logic [7:0]  rsp_block_number;
   logic [1:0]  rsp_status;
   logic        rsp_pool_empty;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   pool_tracker_type pool = new();
   logic [31:0]      held_blocks [$];
   pool_result_type  last_result;

   fixed_block_pool_allocator #(.MAX_BLOCKS(POOL_DEPTH)) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_free_address(req_free_address),
      .rsp_valid(rsp_valid),
      .rsp_block_address(rsp_block_address),
      .rsp_block_number(rsp_block_number),
      .rsp_status(rsp_status),
      .rsp_pool_empty(rsp_pool_empty),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         pool.check_response(pool_result_type'({rsp_block_address, rsp_block_number,
                                                rsp_status, rsp_pool_empty}));
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      pool.set_register(idx, value);
      @(posedge clock);
   endtask

   task automatic set_pool(logic [31:0] base, logic [15:0] size, logic [7:0] count);
      csr_write(fbpa_pkg::REG_BASE, base);
      csr_write(fbpa_pkg::REG_SIZE, {16'd0, size});
      csr_write(fbpa_pkg::REG_COUNT, {24'd0, count});
      held_blocks.delete();
   endtask

   // start stays high across back-to-back items, dropped only for a gap
   task automatic issue(logic [1:0] cmd, logic [31:0] addr, bit steady);
      if (!steady && $urandom_range(99) < 26) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_cmd          <= cmd;
      req_free_address <= addr;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
      last_result = pool.note_request(cmd, addr);
      if (cmd == fbpa_pkg::CMD_ALLOC && last_result.status == fbpa_pkg::STATUS_OK)
         held_blocks.push_back(last_result.addr);
      if (cmd == fbpa_pkg::CMD_INIT)
         held_blocks.delete();
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pool.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] stray_address();
      logic [31:0] sz;
      sz = pool.block_bytes();
      case ($urandom_range(3))
         0: return $urandom();
         1: return pool.cfg_base + $urandom_range(0, 300) * sz;
         2: return pool.cfg_base + $urandom_range(0, 20) * sz + ($urandom() % sz);
         default: return pool.cfg_base - $urandom_range(1, 4096);
      endcase
   endfunction

   task automatic run_phase(int n_items, bit steady);
      int pick;
      int idx;
      issue(fbpa_pkg::CMD_INIT, $urandom(), steady);
      for (int k = 0; k < n_items; k++) begin
         pick = $urandom_range(99);
         if (pick < 40 || (pick < 75 && held_blocks.size() == 0)) begin
            issue(fbpa_pkg::CMD_ALLOC, $urandom(), steady);
         end else if (pick < 75) begin
            idx = $urandom_range(0, held_blocks.size() - 1);
            issue(fbpa_pkg::CMD_FREE, held_blocks[idx], steady);
            // now and then keep the address so it is freed twice
            if ($urandom_range(9) != 0) held_blocks.delete(idx);
         end else if (pick < 89) begin
            issue(fbpa_pkg::CMD_FREE, stray_address(), steady);
         end else if (pick < 94) begin
            issue(fbpa_pkg::CMD_INIT, $urandom(), steady);
         end else if (pick < 97) begin
            issue(CMD_UNDEF, $urandom(), steady);
         end else if (!steady) begin
            wait_idle();
         end else begin
            issue(fbpa_pkg::CMD_ALLOC, $urandom(), steady);
         end
      end
      wait_idle();
   endtask

   initial begin
      logic [31:0] base;
      logic [15:0] size;
      logic [7:0]  count;
      int          guard;

      reset            <= 1'b1;
      start            <= 1'b0;
      req_cmd          <= fbpa_pkg::CMD_ALLOC;
      req_free_address <= 32'd0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= 4'd0;
      pwdata           <= 32'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: allocate from the empty list, an undefined command, then a free before any initialize
      issue(fbpa_pkg::CMD_ALLOC, 32'd0, 1'b0);
      issue(CMD_UNDEF, 32'hFFFF_FFFF, 1'b0);
      issue(fbpa_pkg::CMD_FREE, 32'd0, 1'b0);
      issue(fbpa_pkg::CMD_ALLOC, 32'd0, 1'b0);
      wait_idle();

      set_pool(32'h0000_1000, 16'h0040, 8'd4);
      issue(fbpa_pkg::CMD_INIT, 32'd0, 1'b0);
      repeat (5) issue(fbpa_pkg::CMD_ALLOC, 32'd0, 1'b0);
      issue(fbpa_pkg::CMD_FREE, 32'h0000_1080, 1'b0);
      issue(fbpa_pkg::CMD_FREE, 32'h0000_1080, 1'b0);
      issue(fbpa_pkg::CMD_ALLOC, 32'd0, 1'b0);
      issue(fbpa_pkg::CMD_ALLOC, 32'd0, 1'b0);
      issue(fbpa_pkg::CMD_FREE, 32'h0000_0FFF, 1'b0);
      issue(fbpa_pkg::CMD_FREE, 32'h0000_1041, 1'b0);
      issue(fbpa_pkg::CMD_FREE, 32'h0000_1100, 1'b0);
      issue(fbpa_pkg::CMD_FREE, 32'hFFFF_FFFF, 1'b0);
      issue(fbpa_pkg::CMD_FREE, 32'h0000_1000, 1'b0);
      issue(fbpa_pkg::CMD_INIT, 32'd0, 1'b0);
      wait_idle();

      // zero size acts as one byte, zero count leaves nothing to hand out
      set_pool(32'd0, 16'd0, 8'd0);
      issue(fbpa_pkg::CMD_INIT, 32'd0, 1'b0);
      issue(fbpa_pkg::CMD_FREE, 32'd0, 1'b0);
      issue(fbpa_pkg::CMD_ALLOC, 32'd0, 1'b0);
      wait_idle();

      for (int ph = 0; ph < 10; ph++) begin
         base  = ($urandom_range(2) == 0) ? 32'($urandom_range(0, 4095)) : $urandom();
         size  = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 64));
         count = ($urandom_range(4) == 0) ? 8'($urandom()) : 8'($urandom_range(1, 16));
         case (ph)
            0: begin base = 32'hFFFF_FF00; size = 16'hFFFF; count = 8'd255; end
            1: begin base = 32'd0; size = 16'd1; count = 8'd254; end
            2: count = 8'd0;
            default: ;
         endcase
         set_pool(base, size, count);
         run_phase(48, ph == 4);
      end

      guard = 0;
      while (pool.outstanding() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      if (pool.outstanding() != 0)
         $error("%0d results never arrived", pool.outstanding());
      if (pool.errors == 0 && pool.outstanding() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
